>>> src/hqk_pkg.sv
// ----------------------------------------------------------------------------
// hqk_pkg
// shared types, codes and the half-qwerty mirror table
// ----------------------------------------------------------------------------
package hqk_pkg;

  // opcode values on the input channel
  localparam logic [2:0] OP_LEGACY = 3'd0;
  localparam logic [2:0] OP_DOWN   = 3'd1;
  localparam logic [2:0] OP_UP     = 3'd2;
  localparam logic [2:0] OP_TICK   = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  // keyboard modes
  localparam logic [1:0] MODE_LEFT  = 2'd0;
  localparam logic [1:0] MODE_RIGHT = 2'd1;
  localparam logic [1:0] MODE_WIDE  = 2'd2;

  // register indexes on the config port
  localparam logic CFG_MODE    = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  // special key codes
  localparam logic [7:0] KEY_NONE  = 8'd0;
  localparam logic [7:0] KEY_BS    = 8'd8;
  localparam logic [7:0] KEY_SPACE = 8'd32;
  localparam logic [7:0] KEY_DEL   = 8'd127;

  localparam logic [9:0] TIMEOUT_RESET = 10'd267;
  localparam logic [9:0] TIMEOUT_MIN   = 10'd50;
  localparam logic [9:0] TIMEOUT_MAX   = 10'd1000;
  localparam logic [9:0] ELAPSED_MAX   = 10'd1023;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef enum logic [2:0] {
    K_LEGACY,
    K_DOWN,
    K_UP,
    K_TICK,
    K_CLEAR,
    K_NOP
  } kind_t;

  typedef enum logic [1:0] {
    KC_ZERO,
    KC_SPACE,
    KC_EDIT,
    KC_OTHER
  } kclass_t;

  // one classified item between front and back
  typedef struct packed {
    kind_t      kind;
    kclass_t    kclass;
    logic [7:0] key;
    logic [7:0] mapped;
  } item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [9:0] tmo_limit;
  } cfg_t;

  function automatic logic [7:0] mirror_of(input logic [7:0] k);
    logic [7:0] m;
    case (k)
      "q": m = "p";  "p": m = "q";  "w": m = "o";  "o": m = "w";
      "e": m = "i";  "i": m = "e";  "r": m = "u";  "u": m = "r";
      "t": m = "y";  "y": m = "t";  "a": m = ";";  ";": m = "a";
      "s": m = "l";  "l": m = "s";  "d": m = "k";  "k": m = "d";
      "f": m = "j";  "j": m = "f";  "g": m = "h";  "h": m = "g";
      "z": m = "/";  "/": m = "z";  "x": m = ".";  ".": m = "x";
      "c": m = ",";  ",": m = "c";  "v": m = "m";  "m": m = "v";
      "b": m = "n";  "n": m = "b";
      "Q": m = "P";  "P": m = "Q";  "W": m = "O";  "O": m = "W";
      "E": m = "I";  "I": m = "E";  "R": m = "U";  "U": m = "R";
      "T": m = "Y";  "Y": m = "T";  "A": m = ":";  ":": m = "A";
      "S": m = "L";  "L": m = "S";  "D": m = "K";  "K": m = "D";
      "F": m = "J";  "J": m = "F";  "G": m = "H";  "H": m = "G";
      "Z": m = "?";  "?": m = "Z";  "X": m = ">";  ">": m = "X";
      "C": m = "<";  "<": m = "C";  "V": m = "M";  "M": m = "V";
      "B": m = "N";  "N": m = "B";
      "1": m = "0";  "0": m = "1";  "2": m = "9";  "9": m = "2";
      "3": m = "8";  "8": m = "3";  "4": m = "7";  "7": m = "4";
      "5": m = "6";  "6": m = "5";
      default: m = k;
    endcase
    return m;
  endfunction

endpackage

>>> src/hqk_front.sv
// ----------------------------------------------------------------------------
// hqk_front
// classifies an incoming event and looks up its mirrored key
// ----------------------------------------------------------------------------
module hqk_front (
  input  logic [2:0]     opcode,
  input  logic [7:0]     key_code,
  input  logic [1:0]     mode,
  output hqk_pkg::item_t item
);
  import hqk_pkg::*;

  always_comb begin
    case (opcode)
      OP_LEGACY: item.kind = K_LEGACY;
      OP_DOWN:   item.kind = K_DOWN;
      OP_UP:     item.kind = K_UP;
      OP_TICK:   item.kind = K_TICK;
      OP_CLEAR:  item.kind = K_CLEAR;
      default:   item.kind = K_NOP;
    endcase

    if (key_code == KEY_NONE) begin
      item.kclass = KC_ZERO;
    end else if (key_code == KEY_SPACE) begin
      item.kclass = KC_SPACE;
    end else if (key_code == KEY_BS || key_code == KEY_DEL) begin
      item.kclass = KC_EDIT;
    end else begin
      item.kclass = KC_OTHER;
    end

    item.key = key_code;
    // identity mapping in the other mode
    item.mapped = (mode == MODE_LEFT || mode == MODE_RIGHT || mode == MODE_WIDE) ?
                  mirror_of(key_code) : key_code;
  end

endmodule

>>> src/hqk_fifo.sv
// ----------------------------------------------------------------------------
// hqk_fifo
// small register queue of classified items between front and back
// ----------------------------------------------------------------------------
module hqk_fifo #(
  parameter int DEPTH = hqk_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hqk_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output hqk_pkg::item_t head
);
  import hqk_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  item_t           mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/hqk_back.sv
// ----------------------------------------------------------------------------
// hqk_back
// space modifier state, timer and the registered result
// ----------------------------------------------------------------------------
module hqk_back (
  input  logic           clk,
  input  logic           rst,
  input  hqk_pkg::cfg_t  cfg,
  input  logic           item_valid,
  input  hqk_pkg::item_t item,
  output logic           item_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           handled,
  output logic           char_valid,
  output logic [7:0]     out_char,
  output logic           space_is_down,
  output logic           space_was_used
);
  import hqk_pkg::*;

  logic       space_latched, space_latched_next;
  logic       space_held, space_held_next;
  logic       combo_used, combo_used_next;
  logic       timer_running, timer_running_next;
  logic [9:0] elapsed_ms, elapsed_ms_next;
  logic       hnd;
  logic       cv;
  logic [7:0] ch;
  logic       side_mode;

  assign item_pop  = item_valid && (!out_valid || out_ready);
  assign side_mode = (cfg.mode == MODE_LEFT) || (cfg.mode == MODE_RIGHT);

  always_comb begin
    space_latched_next = space_latched;
    space_held_next    = space_held;
    combo_used_next    = combo_used;
    timer_running_next = timer_running;
    elapsed_ms_next    = elapsed_ms;
    hnd = 1'b0;
    cv  = 1'b0;
    ch  = KEY_NONE;

    case (item.kind)
      K_LEGACY: begin
        case (item.kclass)
          KC_SPACE: begin
            hnd = 1'b1;
            if (space_latched) begin
              cv = 1'b1;
              ch = KEY_SPACE;
              space_latched_next = 1'b0;
              timer_running_next = 1'b0;
            end else begin
              space_latched_next = 1'b1;
              timer_running_next = 1'b1;
              elapsed_ms_next    = '0;
            end
          end
          KC_EDIT: begin
            hnd = 1'b1;
            cv  = 1'b1;
            ch  = item.key;
          end
          KC_OTHER: begin
            hnd = 1'b1;
            cv  = 1'b1;
            if (side_mode || space_latched || space_held) begin
              ch = item.mapped;
              combo_used_next = 1'b1;
              // wide mode keeps the latch for typing in a row
              if (cfg.mode != MODE_WIDE) begin
                space_latched_next = 1'b0;
                timer_running_next = 1'b0;
              end
            end else begin
              ch = item.key;
            end
          end
          default: begin
            // timeout poll
            if (space_latched && timer_running && elapsed_ms >= cfg.tmo_limit) begin
              hnd = 1'b1;
              cv  = 1'b1;
              ch  = KEY_SPACE;
              space_latched_next = 1'b0;
              timer_running_next = 1'b0;
            end
          end
        endcase
      end
      K_DOWN: begin
        case (item.kclass)
          KC_SPACE: begin
            hnd = 1'b1;
            space_held_next = 1'b1;
            combo_used_next = 1'b0;
          end
          KC_EDIT: begin
            hnd = 1'b1;
            cv  = 1'b1;
            ch  = item.key;
          end
          KC_OTHER: begin
            hnd = 1'b1;
            cv  = 1'b1;
            if (side_mode || space_held || space_latched) begin
              ch = item.mapped;
              combo_used_next    = 1'b1;
              space_latched_next = 1'b0;
              timer_running_next = 1'b0;
            end else begin
              ch = item.key;
            end
          end
          default: begin
          end
        endcase
      end
      K_UP: begin
        if (item.kclass == KC_SPACE && space_held) begin
          hnd = 1'b1;
          space_held_next = 1'b0;
          if (!combo_used) begin
            cv = 1'b1;
            ch = KEY_SPACE;
          end else begin
            combo_used_next = 1'b0;
          end
        end
      end
      K_TICK: begin
        if (timer_running && elapsed_ms < ELAPSED_MAX) begin
          elapsed_ms_next = elapsed_ms + 1'b1;
        end
      end
      K_CLEAR: begin
        space_latched_next = 1'b0;
        space_held_next    = 1'b0;
        combo_used_next    = 1'b0;
        timer_running_next = 1'b0;
        elapsed_ms_next    = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      space_latched <= 1'b0;
      space_held    <= 1'b0;
      combo_used    <= 1'b0;
      timer_running <= 1'b0;
      elapsed_ms    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (item_pop) begin
        space_latched <= space_latched_next;
        space_held    <= space_held_next;
        combo_used    <= combo_used_next;
        timer_running <= timer_running_next;
        elapsed_ms    <= elapsed_ms_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      handled        <= hnd;
      char_valid     <= cv;
      out_char       <= ch;
      space_is_down  <= space_held_next;
      space_was_used <= combo_used_next;
    end
  end

endmodule

>>> src/half_qwerty_key_mapper.sv
// ----------------------------------------------------------------------------
// half_qwerty_key_mapper
// half-qwerty keyboard mirroring with space used as a modifier
// ----------------------------------------------------------------------------
//   channel   signals                                         role
//   in        in_valid/in_ready, opcode, key_code             key events, ticks
//   out       out_valid/out_ready, handled, char_valid,       one result per item
//             out_char, space_is_down, space_was_used
//   cfg       cfg_we, cfg_index, cfg_data                     mode, space timeout
//
// one item per cycle sustained while the output is not stalled; the queue is
// written at the accepting edge, the result register when the item is popped
// the front classifies and mirrors an item in the cycle it is accepted; the
// back end applies it to the space state when the result register is free
// reset is synchronous: queue emptied, space state cleared, mode left,
// timeout 267 ms
// a stalled output fills the queue, after which in_ready drops
module half_qwerty_key_mapper #(
  parameter int QUEUE_DEPTH = hqk_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] opcode,
  input  logic [7:0] key_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       handled,
  output logic       char_valid,
  output logic [7:0] out_char,
  output logic       space_is_down,
  output logic       space_was_used,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [9:0] cfg_data
);
  import hqk_pkg::*;

  cfg_t  cfg;
  item_t front_item;
  item_t head_item;
  logic  q_full;
  logic  q_not_empty;
  logic  q_pop;
  logic  accept;

  // config registers; out-of-range timeouts are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode      <= MODE_LEFT;
      cfg.tmo_limit <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE: cfg.mode <= cfg_data[1:0];
        CFG_TIMEOUT: begin
          if (cfg_data >= TIMEOUT_MIN && cfg_data <= TIMEOUT_MAX) begin
            cfg.tmo_limit <= cfg_data;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // front: decode and mirror lookup
  hqk_front u_front (
    .opcode   (opcode),
    .key_code (key_code),
    .mode     (cfg.mode),
    .item     (front_item)
  );

  // queue between front and back
  hqk_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_item)
  );

  // back: space state, timer and output register
  hqk_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .item_valid     (q_not_empty),
    .item           (head_item),
    .item_pop       (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .handled        (handled),
    .char_valid     (char_valid),
    .out_char       (out_char),
    .space_is_down  (space_is_down),
    .space_was_used (space_was_used)
  );

  // no character means a zero char field
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !char_valid |-> out_char == KEY_NONE)
    else $error("out_char set without char_valid");

  // a committed character always comes from a handled event
  assert property (@(posedge clk) disable iff (rst)
    out_valid && char_valid |-> handled)
    else $error("character committed on unhandled item");

  // the timeout register never leaves its legal range
  assert property (@(posedge clk) disable iff (rst)
    cfg.tmo_limit >= TIMEOUT_MIN && cfg.tmo_limit <= TIMEOUT_MAX)
    else $error("space timeout out of range");

  // a stalled result is not overwritten by the back end
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !q_pop)
    else $error("back end popped while result stalled");

endmodule

>>> tb/sv/half_qwerty_key_mapper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_qwerty_key_mapper_tb
// Drives key events, ticks and clears into the mapper through its valid/ready
// input, predicts each result with a behavioral keyboard model kept in the
// bench, and checks every result item field by field in order of arrival.
// ----------------------------------------------------------------------------
module half_qwerty_key_mapper_tb;
  import hqk_pkg::*;

  // codes the package does not name
  localparam logic [1:0] MODE_PLAIN = 2'd3;   // identity mapping
  localparam logic [2:0] OP_LAST    = 3'd7;   // highest opcode value
  localparam int WATCHDOG_LIMIT     = 4000;   // cycles with no item moving
  localparam int SEGMENT_ITEMS      = 16;     // minimum input items per random segment
  localparam int MAX_REPORTS        = 10;

  typedef struct packed {
    logic       handled;
    logic       char_valid;
    logic [7:0] ch;
    logic       down;
    logic       used;
  } key_result_t;

  // dut ports, all inputs driven to known values from time zero
  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [2:0] opcode    = OP_TICK;
  logic [7:0] key_code  = KEY_NONE;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       handled;
  logic       char_valid;
  logic [7:0] out_char;
  logic       space_is_down;
  logic       space_was_used;
  logic       cfg_we    = 1'b0;
  logic       cfg_index = CFG_MODE;
  logic [9:0] cfg_data  = '0;

  half_qwerty_key_mapper u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .key_code       (key_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .handled        (handled),
    .char_valid     (char_valid),
    .out_char       (out_char),
    .space_is_down  (space_is_down),
    .space_was_used (space_was_used),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // keyboard model: registers and space-modifier state as the bench sees them
  // ---------------------------------------------------------------------------
  logic [1:0] kbd_mode;
  logic [9:0] kbd_timeout;
  logic       sp_latched;
  logic       sp_held;
  logic       sp_combo;
  logic       tmr_running;
  logic [9:0] elapsed;

  // mirror pairs: character i of one row swaps with character i of the other
  string left_row  = "qwertasdfgzxcvbQWERTASDFGZXCVB12345";
  string right_row = "poiuy;lkjh/.,mnPOIUY:LKJH?><MN09876";

  key_result_t pending_results[$];   // predicted results not yet seen
  int unsigned mismatches    = 0;
  int unsigned items_sent    = 0;    // accepted input items
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req      = 0;    // long receiver hold asked by a test
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;

  function automatic logic [7:0] twin_key(input logic [7:0] k);
    for (int i = 0; i < left_row.len(); i++) begin
      if (left_row[i] == k) return right_row[i];
      if (right_row[i] == k) return left_row[i];
    end
    return k;
  endfunction

  function automatic void clear_space_state();
    sp_latched  = 1'b0;
    sp_held     = 1'b0;
    sp_combo    = 1'b0;
    tmr_running = 1'b0;
    elapsed     = '0;
  endfunction

  function automatic void set_register(input logic idx, input logic [9:0] data);
    if (idx == CFG_MODE) begin
      kbd_mode = data[1:0];
    end else if (data >= TIMEOUT_MIN && data <= TIMEOUT_MAX) begin
      kbd_timeout = data;   // out-of-range writes keep the old timeout
    end
  endfunction

  // applies one event to the model and returns the result item it causes
  function automatic key_result_t predict_keystroke(input logic [2:0] op,
                                                    input logic [7:0] key);
    key_result_t r;
    logic        side;
    logic        hit;
    logic        commit;
    logic [7:0]  ch;
    side   = (kbd_mode == MODE_LEFT) || (kbd_mode == MODE_RIGHT);
    hit    = 1'b0;
    commit = 1'b0;
    ch     = KEY_NONE;
    case (op)
      OP_LEGACY: begin
        if (key == KEY_SPACE) begin
          hit = 1'b1;
          if (sp_latched) begin
            // second legacy space commits and unlatches
            commit      = 1'b1;
            ch          = KEY_SPACE;
            sp_latched  = 1'b0;
            tmr_running = 1'b0;
          end else begin
            sp_latched  = 1'b1;
            tmr_running = 1'b1;
            elapsed     = '0;
          end
        end else if (key != KEY_NONE) begin
          hit    = 1'b1;
          commit = 1'b1;
          if (key == KEY_BS || key == KEY_DEL) begin
            ch = key;
          end else if (side || sp_latched || sp_held) begin
            ch       = (kbd_mode <= MODE_WIDE) ? twin_key(key) : key;
            sp_combo = 1'b1;
            // wide mode keeps the latch so keys can be typed in a row
            if (kbd_mode != MODE_WIDE) begin
              sp_latched  = 1'b0;
              tmr_running = 1'b0;
            end
          end else begin
            ch = key;
          end
        end else if (sp_latched && tmr_running && elapsed >= kbd_timeout) begin
          // timeout poll
          hit         = 1'b1;
          commit      = 1'b1;
          ch          = KEY_SPACE;
          sp_latched  = 1'b0;
          tmr_running = 1'b0;
        end
      end
      OP_DOWN: begin
        if (key == KEY_SPACE) begin
          hit      = 1'b1;
          sp_held  = 1'b1;
          sp_combo = 1'b0;
        end else if (key != KEY_NONE) begin
          hit    = 1'b1;
          commit = 1'b1;
          if (key == KEY_BS || key == KEY_DEL) begin
            ch = key;
          end else if (side || sp_held || sp_latched) begin
            ch          = (kbd_mode <= MODE_WIDE) ? twin_key(key) : key;
            sp_combo    = 1'b1;
            sp_latched  = 1'b0;
            tmr_running = 1'b0;
          end else begin
            ch = key;
          end
        end
      end
      OP_UP: begin
        if (key == KEY_SPACE && sp_held) begin
          hit     = 1'b1;
          sp_held = 1'b0;
          if (!sp_combo) begin
            commit = 1'b1;
            ch     = KEY_SPACE;
          end else begin
            sp_combo = 1'b0;
          end
        end
      end
      OP_TICK: begin
        if (tmr_running && elapsed < ELAPSED_MAX) elapsed = elapsed + 10'd1;
      end
      OP_CLEAR: begin
        clear_space_state();
      end
      default: begin
      end
    endcase
    r.handled    = hit;
    r.char_valid = commit;
    r.ch         = commit ? ch : KEY_NONE;
    r.down       = sp_held;
    r.used       = sp_combo;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // offers one item from the falling edge on; returns at the accepting edge
  task automatic send_item(input logic [2:0] op, input logic [7:0] key);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    key_code <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_keystroke(op, key));
    items_sent++;
  endtask

  // stops offering and waits until every predicted result has come back
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // queue and result register drained, a little margin on top
    repeat (4) @(posedge clk);
  endtask

  // register write; only called while the block is idle
  task automatic write_reg(input logic idx, input logic [9:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    set_register(idx, data);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mode write with random junk in the unused upper bits
  task automatic write_mode(input logic [1:0] m);
    write_reg(CFG_MODE, {8'($urandom_range(255)), m});
  endtask

  // ---------------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------------

  // receiver: a requested hold wins, otherwise random stalls
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker: each result against the oldest prediction
  key_result_t want;
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result item: handled %b char %b/%02h down %b used %b",
                   $realtime, handled, char_valid, out_char, space_is_down,
                   space_was_used);
      end else begin
        want = pending_results.pop_front();
        if (handled !== want.handled || char_valid !== want.char_valid ||
            out_char !== want.ch || space_is_down !== want.down ||
            space_was_used !== want.used) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"%0t: result mismatch: expected handled %b char %b/%02h down %b used %b,",
                      " got handled %b char %b/%02h down %b used %b"}, $realtime,
                     want.handled, want.char_valid, want.ch, want.down, want.used,
                     handled, char_valid, out_char, space_is_down, space_was_used);
        end
      end
    end
  end

  // watchdog: too long with no item moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("half_qwerty_key_mapper_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly mirrorable keys, some edit keys and space, the rest anything
  function automatic logic [7:0] pick_key();
    int unsigned r;
    int unsigned i;
    r = $urandom_range(99);
    i = $urandom_range(left_row.len() - 1);
    if (r < 55) return $urandom_range(1) ? left_row[i] : right_row[i];
    if (r < 70) return $urandom_range(1) ? KEY_BS : KEY_DEL;
    if (r < 78) return KEY_SPACE;
    return 8'($urandom_range(255));
  endfunction

  // a short burst, or right around the timeout when it is short
  task automatic tick_burst();
    int unsigned n;
    if ($urandom_range(1) && kbd_timeout <= 10'd70) n = kbd_timeout - 2 + $urandom_range(4);
    else n = $urandom_range(20);
    repeat (n) send_item(OP_TICK, 8'($urandom_range(255)));
  endtask

  // legacy space, exactly len-1 ticks, a poll (no commit yet), last tick, poll
  task automatic check_timeout_edge(input int unsigned len);
    send_item(OP_LEGACY, KEY_SPACE);
    repeat (len - 1) send_item(OP_TICK, KEY_NONE);
    send_item(OP_LEGACY, KEY_NONE);
    send_item(OP_TICK, KEY_NONE);
    send_item(OP_LEGACY, KEY_NONE);
  endtask

  // one random chord, run of typing, noise or broken sequence
  task automatic run_sequence();
    int unsigned r;
    logic [7:0]  k;
    r = $urandom_range(99);
    if (r < 35) begin
      // legacy space chord
      send_item(OP_LEGACY, KEY_SPACE);
      repeat ($urandom_range(3))
        send_item($urandom_range(1) ? OP_LEGACY : OP_DOWN, pick_key());
      case ($urandom_range(2))
        0: send_item(OP_LEGACY, KEY_SPACE);
        1: begin
          tick_burst();
          send_item(OP_LEGACY, KEY_NONE);
        end
        default: send_item(OP_LEGACY, KEY_NONE);
      endcase
    end else if (r < 65) begin
      // held space chord
      send_item(OP_DOWN, KEY_SPACE);
      repeat ($urandom_range(3)) begin
        k = pick_key();
        send_item(OP_DOWN, k);
        if ($urandom_range(1)) send_item(OP_UP, k);
      end
      if ($urandom_range(3) == 0) send_item(OP_TICK, KEY_NONE);
      send_item(OP_UP, KEY_SPACE);
    end else if (r < 80) begin
      repeat ($urandom_range(1, 4))
        send_item($urandom_range(1) ? OP_LEGACY : OP_DOWN, pick_key());
    end else if (r < 90) begin
      send_item(3'($urandom_range(OP_LAST)), 8'($urandom_range(255)));
    end else begin
      // broken sequences
      case ($urandom_range(4))
        0: send_item(OP_CLEAR, 8'($urandom_range(255)));
        1: send_item(OP_UP, KEY_SPACE);
        2: begin
          send_item(OP_LEGACY, KEY_SPACE);
          send_item(OP_CLEAR, KEY_NONE);
          send_item(OP_LEGACY, KEY_NONE);
        end
        3: begin
          send_item(OP_DOWN, KEY_SPACE);
          send_item(OP_CLEAR, KEY_NONE);
          send_item(OP_UP, KEY_SPACE);
        end
        default: send_item(OP_LEGACY, KEY_NONE);
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset mode (half left), field extremes, every opcode, the plain special cases
  task automatic test_basic_events();
    send_item(OP_LEGACY, "q");          // side mode mirrors even without space
    send_item(OP_DOWN, "Z");
    send_item(OP_LEGACY, KEY_BS);       // edit keys pass through
    send_item(OP_DOWN, KEY_DEL);
    send_item(OP_LEGACY, KEY_NONE);     // poll with nothing latched
    send_item(OP_DOWN, KEY_NONE);       // zero code down/up is ignored
    send_item(OP_UP, KEY_NONE);
    send_item(OP_UP, "a");              // release of a non-space key
    send_item(OP_UP, KEY_SPACE);        // release of space never pressed
    send_item(OP_LEGACY, 8'hFF);
    send_item(OP_DOWN, 8'h80);
    send_item(OP_TICK, 8'h55);          // tick with timer stopped
    for (int op = OP_CLEAR + 1; op <= OP_LAST; op++)
      send_item(3'(op), 8'($urandom_range(255)));
    send_item(OP_LEGACY, KEY_SPACE);    // latch, then second space commits
    send_item(OP_LEGACY, KEY_SPACE);
    send_item(OP_DOWN, KEY_SPACE);      // tap commits space on release
    send_item(OP_UP, KEY_SPACE);
    send_item(OP_DOWN, KEY_SPACE);      // combination, no space on release
    send_item(OP_DOWN, "e");
    send_item(OP_UP, KEY_SPACE);
    send_item(OP_LEGACY, KEY_SPACE);    // clear drops the latch
    send_item(OP_CLEAR, KEY_NONE);
    send_item(OP_LEGACY, KEY_NONE);
  endtask

  // wide, identity and right modes
  task automatic test_modes();
    wait_idle();
    write_mode(MODE_WIDE);
    send_item(OP_LEGACY, "q");          // no space: passes through
    send_item(OP_LEGACY, KEY_SPACE);
    send_item(OP_LEGACY, "q");          // latch stays in wide mode
    send_item(OP_LEGACY, "w");
    send_item(OP_DOWN, "1");            // key down drops the latch
    send_item(OP_LEGACY, "t");
    send_item(OP_DOWN, KEY_SPACE);
    send_item(OP_DOWN, ";");
    send_item(OP_UP, KEY_SPACE);
    wait_idle();
    write_mode(MODE_PLAIN);
    send_item(OP_DOWN, KEY_SPACE);      // identity, still a combination
    send_item(OP_DOWN, "q");
    send_item(OP_UP, KEY_SPACE);
    send_item(OP_LEGACY, KEY_SPACE);
    send_item(OP_LEGACY, "5");
    send_item(OP_LEGACY, "?");
    wait_idle();
    write_mode(MODE_RIGHT);
    send_item(OP_LEGACY, "t");
    send_item(OP_DOWN, "/");
  endtask

  // timeout register bounds, poll boundary and counter saturation
  task automatic test_space_timeout();
    wait_idle();
    write_reg(CFG_TIMEOUT, TIMEOUT_MIN);
    write_reg(CFG_TIMEOUT, 10'd0);            // ignored from here on
    write_reg(CFG_TIMEOUT, TIMEOUT_MIN - 1);
    write_reg(CFG_TIMEOUT, TIMEOUT_MAX + 1);
    write_reg(CFG_TIMEOUT, ELAPSED_MAX);
    check_timeout_edge(kbd_timeout);
    wait_idle();
    write_reg(CFG_TIMEOUT, TIMEOUT_MAX);
    // run the counter past its top; a wrap would miss the poll
    send_item(OP_LEGACY, KEY_SPACE);
    repeat (TIMEOUT_MAX - 1) send_item(OP_TICK, KEY_NONE);
    send_item(OP_LEGACY, KEY_NONE);           // one short of the timeout
    repeat (ELAPSED_MAX - TIMEOUT_MAX + 8) send_item(OP_TICK, KEY_NONE);
    send_item(OP_LEGACY, KEY_NONE);
  endtask

  // receiver holds off long enough for the input to stall
  task automatic test_backpressure();
    wait_idle();
    send_idle_pct = 0;
    @(posedge clk);
    hold_req = 60;
    repeat (16) send_item(OP_DOWN, pick_key());
    wait_idle();
  endtask

  // random chords in segments, each with its own settings and idling
  task automatic test_random_traffic();
    int unsigned goal;
    logic [1:0]  seg_mode;
    logic [9:0]  seg_timeout;
    for (int seg = 0; seg < 6; seg++) begin
      wait_idle();
      case (seg / 2)
        0: begin send_idle_pct = 22; recv_idle_pct = 69; end
        1: begin send_idle_pct = 69; recv_idle_pct = 22; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (seg)
        0: begin seg_mode = MODE_LEFT;  seg_timeout = TIMEOUT_MIN; end
        1: begin seg_mode = MODE_WIDE;  seg_timeout = 10'($urandom_range(50, 70)); end
        2: begin seg_mode = MODE_RIGHT; seg_timeout = TIMEOUT_MAX; end
        3: begin seg_mode = MODE_PLAIN; seg_timeout = 10'($urandom_range(50, 70)); end
        4: begin seg_mode = MODE_WIDE;  seg_timeout = TIMEOUT_MIN; end
        default: begin
          seg_mode    = 2'($urandom_range(3));
          seg_timeout = 10'($urandom_range(50, 90));
        end
      endcase
      write_mode(seg_mode);
      write_reg(CFG_TIMEOUT, seg_timeout);
      // an out-of-range write that must not stick
      write_reg(CFG_TIMEOUT, $urandom_range(1) ? 10'($urandom_range(0, 49))
                                               : 10'($urandom_range(1001, 1023)));
      goal = items_sent + SEGMENT_ITEMS;
      while (items_sent < goal) begin
        run_sequence();
        if ($urandom_range(39) == 0) wait_idle();     // sender pauses to drain
        if ($urandom_range(59) == 0) hold_req = $urandom_range(20, 50);
      end
    end
  endtask

  initial begin
    kbd_mode    = MODE_LEFT;
    kbd_timeout = TIMEOUT_RESET;
    clear_space_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 22;
    recv_idle_pct = 69;
    test_basic_events();
    test_modes();
    test_space_timeout();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    repeat (10) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("half_qwerty_key_mapper_tb: PASS");
    end else begin
      $display("half_qwerty_key_mapper_tb: FAIL");
    end
    $finish;
  end

endmodule
